### hdl/slwg_pkg.sv
`default_nettype none
package slwg_pkg;

  localparam int MAX_OBJ    = 8;
  localparam int FRAC_BITS  = 16;
  localparam int MIN_WEIGHT = 1;

  localparam int COMP_W = FRAC_BITS + 1;
  localparam int CNT_W  = 16;
  localparam int M_W    = 4;
  localparam int SEL_W  = $clog2(MAX_OBJ);
  localparam int BIT_W  = $clog2(CNT_W);
  // (H + M*k) < 2^20, shifted by FRAC_BITS+1, plus rounding term
  localparam int NUM_W  = 20 + FRAC_BITS + 2;
  localparam int DEN_W  = 21;
  localparam int ADR_W  = 3;

  localparam logic [COMP_W-1:0] COMP_MAX = '1;
  localparam logic [COMP_W-1:0] COMP_MIN = COMP_W'(MIN_WEIGHT);
  localparam logic [M_W-1:0]    M_LO     = M_W'(2);
  localparam logic [M_W-1:0]    M_HI     = M_W'(MAX_OBJ);

  localparam logic REG_TARGET = 1'b0;
  localparam logic REG_OBJ    = 1'b1;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_SETUP_INIT,
    OP_TRY,
    OP_BMUL,
    OP_DIV_START,
    OP_BACC,
    OP_GACC,
    OP_FIN1,
    OP_FIN2,
    OP_RESTART,
    OP_CPREP,
    OP_CSTORE,
    OP_EMIT,
    OP_ADV_INC,
    OP_ADV_CLR,
    OP_ADV_WRAP
  } dp_op_e;

  typedef struct packed {
    dp_op_e           op;
    logic [BIT_W-1:0] bit_sel;
    logic [SEL_W-1:0] step;
    logic [SEL_W-1:0] sel;
  } dp_cmd_t;

  typedef struct packed {
    logic           div_done;
    logic           q_gt_thr;
    logic [M_W-1:0] m;
    logic           setup_done;
    logic           ph2_ok;
    logic           adv_fits;
    logic           out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

### hdl/slwg_ifs.sv
`default_nettype none
interface slwg_in_if;
  logic valid;
  logic ready;
  logic restart;
  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface slwg_out_if;
  import slwg_pkg::*;
  logic              valid;
  logic              ready;
  logic [COMP_W-1:0] component_0;
  logic [COMP_W-1:0] component_1;
  logic [COMP_W-1:0] component_2;
  logic [COMP_W-1:0] component_3;
  logic [COMP_W-1:0] component_4;
  logic [COMP_W-1:0] component_5;
  logic [COMP_W-1:0] component_6;
  logic [COMP_W-1:0] component_7;
  logic [CNT_W-1:0]  point_index;
  logic [CNT_W-1:0]  point_total;
  logic              inner_layer;
  logic              last_point;
  modport source (output valid, output component_0, output component_1,
                  output component_2, output component_3, output component_4,
                  output component_5, output component_6, output component_7,
                  output point_index, output point_total, output inner_layer,
                  output last_point, input ready);
  modport sink   (input valid, input component_0, input component_1,
                  input component_2, input component_3, input component_4,
                  input component_5, input component_6, input component_7,
                  input point_index, input point_total, input inner_layer,
                  input last_point, output ready);
endinterface
`default_nettype wire

### hdl/simplex_lattice_weight_generator.sv
`default_nettype none
// Two-layer simplex lattice weight generator: each input word returns one
// weight vector (65536 = 1.0), walking layer one then layer two and wrapping.
// All divisions go through one 38-step restoring divider. A vector needs M
// divisions (one per objective) plus the odometer step. The first word after
// reset or after a register write also runs the lattice setup: up to
// two 16-step bit searches, each trial a binomial of up to M-1
// multiply-and-divide steps.
module simplex_lattice_weight_generator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  slwg_in_if.sink                       in_i,
  slwg_out_if.source                    out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [slwg_pkg::ADR_W-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import slwg_pkg::*;

  logic [CNT_W-1:0] target_q;
  logic [M_W-1:0]   obj_q;
  logic             cfg_wr;
  dp_cmd_t          cmd;
  dp_stat_t         stat;
  logic [MAX_OBJ-1:0][COMP_W-1:0] comp;

  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_OBJ) ? 32'(obj_q) : 32'(target_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= CNT_W'(100);
      obj_q    <= M_W'(3);
    end else if (cfg_wr) begin
      if (paddr[2] == REG_TARGET) begin
        target_q <= pwdata[CNT_W-1:0];
      end else begin
        obj_q <= pwdata[M_W-1:0];
      end
    end
  end

  slwg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_restart_i(in_i.restart),
    .in_ready_o  (in_i.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  slwg_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .target_i   (target_q),
    .obj_i      (obj_q),
    .cfg_wr_i   (cfg_wr),
    .out_ready_i(out_o.ready),
    .out_valid_o(out_o.valid),
    .comp_o     (comp),
    .idx_o      (out_o.point_index),
    .total_o    (out_o.point_total),
    .layer_o    (out_o.inner_layer),
    .last_o     (out_o.last_point)
  );

  assign out_o.component_0 = comp[0];
  assign out_o.component_1 = comp[1];
  assign out_o.component_2 = comp[2];
  assign out_o.component_3 = comp[3];
  assign out_o.component_4 = comp[4];
  assign out_o.component_5 = comp[5];
  assign out_o.component_6 = comp[6];
  assign out_o.component_7 = comp[7];

endmodule
`default_nettype wire

### hdl/slwg_div.sv
`default_nettype none
module slwg_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [slwg_pkg::NUM_W-1:0] num_i,
  input  logic [slwg_pkg::DEN_W-1:0] den_i,
  output logic                       done_o,
  output logic [slwg_pkg::NUM_W-1:0] quot_o
);
  import slwg_pkg::*;

  localparam int C_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem_q, den_q;
  logic [NUM_W-1:0] quo_q;
  logic [C_W-1:0]   cnt_q;
  logic             busy_q, done_q;
  logic [DEN_W:0]   trial;
  logic             fit;

  assign trial = {rem_q, quo_q[NUM_W-1]};
  assign fit   = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= C_W'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - C_W'(1);
        if (cnt_q == C_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= fit ? DEN_W'(trial - {1'b0, den_q}) : DEN_W'(trial);
      quo_q <= {quo_q[NUM_W-2:0], fit};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule
`default_nettype wire

### hdl/slwg_dp.sv
`default_nettype none
module slwg_dp (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  slwg_pkg::dp_cmd_t                                 cmd_i,
  output slwg_pkg::dp_stat_t                                stat_o,
  input  logic [slwg_pkg::CNT_W-1:0]                        target_i,
  input  logic [slwg_pkg::M_W-1:0]                          obj_i,
  input  logic                                              cfg_wr_i,
  input  logic                                              out_ready_i,
  output logic                                              out_valid_o,
  output logic [slwg_pkg::MAX_OBJ-1:0][slwg_pkg::COMP_W-1:0] comp_o,
  output logic [slwg_pkg::CNT_W-1:0]                        idx_o,
  output logic [slwg_pkg::CNT_W-1:0]                        total_o,
  output logic                                              layer_o,
  output logic                                              last_o
);
  import slwg_pkg::*;

  logic [M_W-1:0]   m_q;
  logic [CNT_W-1:0] thr_q, g_q, try_q, c_q, cbest_q, h1_q, h2_q, c1_q, total_q;
  logic [CNT_W-1:0] sum_q, idx_q;
  logic [CNT_W-1:0] pc_q [MAX_OBJ];
  logic             setup_q, layer_q, out_valid_q;
  logic [NUM_W-1:0] num_q;
  logic [DEN_W-1:0] den_q;
  logic [COMP_W-1:0] comp_q [MAX_OBJ];
  logic [MAX_OBJ-1:0][COMP_W-1:0] out_comp_q;
  logic [CNT_W-1:0] out_idx_q, out_total_q;
  logic             out_layer_q, out_last_q;

  logic [NUM_W-1:0] quot;
  logic             div_done;
  logic [CNT_W-1:0] h_cur, ksel;
  logic [19:0]      mk, mh, hmk;
  logic [20:0]      dd;
  logic [32:0]      bprod;
  logic [COMP_W-1:0] cval;
  logic [M_W-1:0]   m_n;
  logic [CNT_W-1:0] h1_n, c1_n;
  logic             fits;
  logic             out_free;

  slwg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.op == OP_DIV_START),
    .num_i  (num_q),
    .den_i  (den_q),
    .done_o (div_done),
    .quot_o (quot)
  );

  always_comb begin
    h_cur = layer_q ? h2_q : h1_q;
    if (cmd_i.sel == '0) begin
      ksel = (sum_q <= h_cur) ? h_cur - sum_q : '0;
    end else begin
      ksel = pc_q[cmd_i.sel];
    end
    mk    = 20'(m_q) * 20'(ksel);
    mh    = 20'(m_q) * 20'(h_cur);
    hmk   = 20'(h_cur) + mk;
    dd    = {mh, 1'b0};
    bprod = 33'(c_q) * 33'(17'(try_q) + 17'(cmd_i.step));
    if (h_cur == '0 || quot < NUM_W'(COMP_MIN)) begin
      cval = COMP_MIN;
    end else if (quot > NUM_W'(COMP_MAX)) begin
      cval = COMP_MAX;
    end else begin
      cval = quot[COMP_W-1:0];
    end
    if (obj_i < M_LO) begin
      m_n = M_LO;
    end else if (obj_i > M_HI) begin
      m_n = M_HI;
    end else begin
      m_n = obj_i;
    end
    h1_n     = (g_q == '0) ? CNT_W'(1) : g_q;
    c1_n     = (g_q == '0) ? CNT_W'(m_q) : cbest_q;
    fits     = (17'(sum_q) + 17'd1) <= 17'(h_cur);
    out_free = !out_valid_q || out_ready_i;
  end

  assign stat_o.div_done   = div_done;
  assign stat_o.q_gt_thr   = quot > NUM_W'(thr_q);
  assign stat_o.m          = m_q;
  assign stat_o.setup_done = setup_q;
  assign stat_o.ph2_ok     = (CNT_W'(m_q) > h1_q) && (c1_q <= target_i);
  assign stat_o.adv_fits   = fits;
  assign stat_o.out_free   = out_free;

  // walk state and handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setup_q     <= 1'b0;
      layer_q     <= 1'b0;
      idx_q       <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
      for (int n = 0; n < MAX_OBJ; n++) begin
        pc_q[n] <= '0;
      end
    end else begin
      if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_wr_i) begin
        setup_q <= 1'b0;
      end
      unique case (cmd_i.op)
        OP_FIN2, OP_RESTART: begin
          if (cmd_i.op == OP_FIN2) begin
            setup_q <= 1'b1;
          end
          layer_q <= 1'b0;
          idx_q   <= '0;
          sum_q   <= '0;
          for (int n = 0; n < MAX_OBJ; n++) begin
            pc_q[n] <= '0;
          end
        end
        OP_EMIT: begin
          out_valid_q <= 1'b1;
        end
        OP_ADV_INC: begin
          pc_q[cmd_i.sel] <= pc_q[cmd_i.sel] + CNT_W'(1);
          sum_q           <= sum_q + CNT_W'(1);
          idx_q           <= idx_q + CNT_W'(1);
        end
        OP_ADV_CLR: begin
          sum_q           <= sum_q - pc_q[cmd_i.sel];
          pc_q[cmd_i.sel] <= '0;
        end
        OP_ADV_WRAP: begin
          sum_q <= '0;
          for (int n = 0; n < MAX_OBJ; n++) begin
            pc_q[n] <= '0;
          end
          if (!layer_q && h2_q != '0) begin
            layer_q <= 1'b1;
            idx_q   <= idx_q + CNT_W'(1);
          end else begin
            layer_q <= 1'b0;
            idx_q   <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // setup search and arithmetic operands
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_SETUP_INIT: begin
        m_q   <= m_n;
        thr_q <= target_i;
        g_q   <= '0;
      end
      OP_TRY: begin
        try_q <= g_q | (CNT_W'(1) << cmd_i.bit_sel);
        c_q   <= CNT_W'(1);
      end
      OP_BMUL: begin
        num_q <= NUM_W'(bprod);
        den_q <= DEN_W'(cmd_i.step);
      end
      OP_BACC: begin
        c_q <= quot[CNT_W-1:0];
      end
      OP_GACC: begin
        g_q     <= try_q;
        cbest_q <= quot[CNT_W-1:0];
      end
      OP_FIN1: begin
        h1_q  <= h1_n;
        c1_q  <= c1_n;
        thr_q <= target_i - c1_n;
        g_q   <= '0;
      end
      OP_FIN2: begin
        h2_q    <= g_q;
        total_q <= c1_q + ((g_q != '0) ? cbest_q : '0);
      end
      OP_CPREP: begin
        if (!layer_q) begin
          num_q <= (NUM_W'(ksel) << (FRAC_BITS + 1)) + NUM_W'(h_cur);
          den_q <= DEN_W'({h_cur, 1'b0});
        end else begin
          num_q <= (NUM_W'(hmk) << (FRAC_BITS + 1)) + NUM_W'(dd);
          den_q <= DEN_W'({dd, 1'b0});
        end
      end
      OP_CSTORE: begin
        comp_q[cmd_i.sel] <= cval;
      end
      OP_EMIT: begin
        for (int n = 0; n < MAX_OBJ; n++) begin
          out_comp_q[n] <= (M_W'(n) < m_q) ? comp_q[n] : '0;
        end
        out_idx_q   <= idx_q;
        out_total_q <= total_q;
        out_layer_q <= layer_q;
        out_last_q  <= (total_q != '0) && (idx_q == total_q - CNT_W'(1));
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign comp_o      = out_comp_q;
  assign idx_o       = out_idx_q;
  assign total_o     = out_total_q;
  assign layer_o     = out_layer_q;
  assign last_o      = out_last_q;

endmodule
`default_nettype wire

### hdl/slwg_ctrl.sv
`default_nettype none
module slwg_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_restart_i,
  output logic               in_ready_o,
  input  slwg_pkg::dp_stat_t stat_i,
  output slwg_pkg::dp_cmd_t  cmd_o
);
  import slwg_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SINIT, ST_TRY, ST_BMUL, ST_BDIV_GO, ST_BDIV_WAIT, ST_NEXTBIT,
    ST_PHASE_END, ST_PH2_CHK, ST_FIN2, ST_CPREP, ST_CDIV_GO, ST_CDIV_WAIT,
    ST_EMIT, ST_ADV
  } state_e;

  state_e           state_q, state_d;
  logic [BIT_W-1:0] b_q, b_d;
  logic [SEL_W-1:0] i_q, i_d;
  logic [M_W-1:0]   j_q, j_d;
  logic             phase_q, phase_d;
  logic [M_W-1:0]   m_last;

  assign m_last     = stat_i.m - M_W'(1);
  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d       = state_q;
    b_d           = b_q;
    i_d           = i_q;
    j_d           = j_q;
    phase_d       = phase_q;
    cmd_o.op      = OP_NONE;
    cmd_o.bit_sel = b_q;
    cmd_o.step    = i_q;
    cmd_o.sel     = j_q[SEL_W-1:0];
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_restart_i) begin
            cmd_o.op = OP_RESTART;
          end
          j_d     = '0;
          state_d = stat_i.setup_done ? ST_CPREP : ST_SINIT;
        end
      end
      ST_SINIT: begin
        cmd_o.op = OP_SETUP_INIT;
        phase_d  = 1'b0;
        b_d      = '1;
        state_d  = ST_TRY;
      end
      ST_TRY: begin
        cmd_o.op = OP_TRY;
        i_d      = SEL_W'(1);
        state_d  = ST_BMUL;
      end
      ST_BMUL: begin
        cmd_o.op = OP_BMUL;
        state_d  = ST_BDIV_GO;
      end
      ST_BDIV_GO: begin
        cmd_o.op = OP_DIV_START;
        state_d  = ST_BDIV_WAIT;
      end
      ST_BDIV_WAIT: begin
        if (stat_i.div_done) begin
          if (stat_i.q_gt_thr) begin
            state_d = ST_NEXTBIT;
          end else if (M_W'(i_q) == m_last) begin
            cmd_o.op = OP_GACC;
            state_d  = ST_NEXTBIT;
          end else begin
            cmd_o.op = OP_BACC;
            i_d      = i_q + SEL_W'(1);
            state_d  = ST_BMUL;
          end
        end
      end
      ST_NEXTBIT: begin
        if (b_q == '0) begin
          state_d = ST_PHASE_END;
        end else begin
          b_d     = b_q - BIT_W'(1);
          state_d = ST_TRY;
        end
      end
      ST_PHASE_END: begin
        if (!phase_q) begin
          cmd_o.op = OP_FIN1;
          state_d  = ST_PH2_CHK;
        end else begin
          state_d = ST_FIN2;
        end
      end
      ST_PH2_CHK: begin
        if (stat_i.ph2_ok) begin
          phase_d = 1'b1;
          b_d     = '1;
          state_d = ST_TRY;
        end else begin
          state_d = ST_FIN2;
        end
      end
      ST_FIN2: begin
        cmd_o.op = OP_FIN2;
        j_d      = '0;
        state_d  = ST_CPREP;
      end
      ST_CPREP: begin
        cmd_o.op = OP_CPREP;
        state_d  = ST_CDIV_GO;
      end
      ST_CDIV_GO: begin
        cmd_o.op = OP_DIV_START;
        state_d  = ST_CDIV_WAIT;
      end
      ST_CDIV_WAIT: begin
        if (stat_i.div_done) begin
          cmd_o.op = OP_CSTORE;
          if (j_q == m_last) begin
            state_d = ST_EMIT;
          end else begin
            j_d     = j_q + M_W'(1);
            state_d = ST_CPREP;
          end
        end
      end
      ST_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.op = OP_EMIT;
          j_d      = M_W'(1);
          state_d  = ST_ADV;
        end
      end
      ST_ADV: begin
        if (j_q == stat_i.m) begin
          cmd_o.op = OP_ADV_WRAP;
          state_d  = ST_IDLE;
        end else if (stat_i.adv_fits) begin
          cmd_o.op = OP_ADV_INC;
          state_d  = ST_IDLE;
        end else begin
          cmd_o.op = OP_ADV_CLR;
          j_d      = j_q + M_W'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      b_q     <= '0;
      i_q     <= '0;
      j_q     <= '0;
      phase_q <= 1'b0;
    end else begin
      state_q <= state_d;
      b_q     <= b_d;
      i_q     <= i_d;
      j_q     <= j_d;
      phase_q <= phase_d;
    end
  end

endmodule
`default_nettype wire
